[rtl/ttwu_pkg.sv]
// Package for the toroidal tile window update block.
// Holds field widths, fixed constants and the sequencer enums.
// No dependencies.
package ttwu_pkg;

    // Field widths
    localparam int CAM_W   = 24;
    localparam int TILE_W  = 21;
    localparam int LEVEL_W = 3;
    localparam int SLOT_W  = 6;

    // Default ring size
    localparam int DEF_GRID_SIZE = 7;

    // Tile width is 5 << (10 - level), so the floor division becomes an
    // arithmetic shift followed by a divide by five.
    localparam logic [3:0]         BASE_SHIFT = 4'd10;
    localparam int                 TILE_DIV   = 5;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL  = 3'd6;
    localparam logic [LEVEL_W-1:0] ZOOM_RESET = 3'd4;

    localparam int RESET_CENTRE = -1000000;
    localparam int FORCE_CENTRE = -10000;

    // Shared divider: operands are 20-bit signed, biased up by d << 19 so
    // that the divide runs unsigned on 23 bits.
    localparam int VAL_W       = 20;
    localparam int U_W         = 23;
    localparam int OFS_SHIFT   = VAL_W - 1;
    localparam int RECIP_SHIFT = 32;

    // Input op codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_FORCE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_CMP,
        S_PREP,
        S_WALK,
        S_DRAIN
    } ttwu_state_t;

    // Operation of the shared divider
    typedef enum logic [1:0] {
        DOP_DIVX,
        DOP_DIVY,
        DOP_MODX,
        DOP_MODY
    } ttwu_dop_t;

endpackage

[rtl/toroidal_tile_window_update_top.sv]
// Top level of the toroidal tile window update block.
// Depends on ttwu_pkg (widths, constants, state and divider enums).
//
// Usage:
//   s_ channel: one transfer per camera position. s_tdata holds cam_x in
//   [23:0] and cam_y in [47:24]; s_tuser is the op (0 update, 1 force).
//   m_ channel: one transfer per reassigned slot, m_tlast on the final
//   slot of a run. An input that leaves the centre tile unchanged gives
//   no transfer at all.
//   cfg_wr_en / cfg_wr_data write zoom_level; write it only while idle.
// Sequence: an item whose centre tile is unchanged ends after the centre
//   compare; any other item goes on to the wrap offsets and the slot walk.
//   The cost is set by the single multiply/correct divider, used twice for
//   the centre and twice more for the wrap offsets, each use a multiply
//   step then a correct step, and by the slot walk that visits one slot per
//   cycle while the receiver keeps up. s_tready is high only between items,
//   so a new input waits until the last one is through.
// Reset (aresetn low, synchronous): stored centre goes to -1000000,
//   zoom_level to 4, all queued results are dropped.
// A stalled receiver holds the walk: the output register keeps its
//   transfer and the walk resumes once m_tready returns.
module toroidal_tile_window_update_top
    import ttwu_pkg::*;
#(
    parameter int GRID_SIZE = DEF_GRID_SIZE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LEVEL_W-1:0] cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // cam_x[23:0], cam_y[47:24]
    input  logic               s_tuser,   // op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // slot_index[5:0], tile_x[26:6],
                                          // tile_y[47:27], tile_level[50:48]
    output logic               m_tlast    // last_of_run
);

    localparam int IDX_W      = $clog2(GRID_SIZE);
    localparam int SLOT_CNT_W = $clog2(GRID_SIZE * GRID_SIZE);
    localparam int HALF       = GRID_SIZE / 2;
    localparam int D_W        = 24;
    localparam int PROD_W     = U_W + RECIP_SHIFT;
    localparam int ITEM_W     = SLOT_W + 2 * TILE_W + LEVEL_W;

    localparam logic [RECIP_SHIFT-1:0] RECIP5 =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / TILE_DIV);
    localparam logic [RECIP_SHIFT-1:0] RECIPG =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / GRID_SIZE);
    localparam logic [U_W-1:0] OFS5 = U_W'(TILE_DIV << OFS_SHIFT);
    localparam logic [U_W-1:0] OFSG = U_W'(GRID_SIZE << OFS_SHIFT);
    localparam logic [U_W-1:0] BIAS = U_W'(1 << OFS_SHIFT);

    localparam int RESET_WRAP_I =
        (((RESET_CENTRE - HALF) % GRID_SIZE) + GRID_SIZE) % GRID_SIZE;
    localparam int FORCE_WRAP_I =
        (((FORCE_CENTRE - HALF) % GRID_SIZE) + GRID_SIZE) % GRID_SIZE;
    localparam logic [IDX_W-1:0] RESET_WRAP = IDX_W'(RESET_WRAP_I);
    localparam logic [IDX_W-1:0] FORCE_WRAP = IDX_W'(FORCE_WRAP_I);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(GRID_SIZE - 1);

    ttwu_state_t state_reg, state_next;
    ttwu_dop_t   dop_reg;

    logic [LEVEL_W-1:0] zoom_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic signed [VAL_W-1:0] sx_reg, sy_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [U_W-1:0]    u_reg;

    logic signed [TILE_W-1:0] cx_reg, cy_reg;      // new centre
    logic [IDX_W-1:0]         nwr_x_reg, nwr_y_reg;
    logic signed [TILE_W-1:0] cen_x_reg, cen_y_reg; // stored centre
    logic [IDX_W-1:0]         cwr_x_reg, cwr_y_reg;

    logic signed [D_W-1:0] dx_reg, dy_reg, bx_reg, by_reg;

    logic [IDX_W-1:0]      i_reg, j_reg;
    logic [SLOT_CNT_W-1:0] slot_reg;

    logic              pend_valid_reg;
    logic [ITEM_W-1:0] pend_data_reg;
    logic              out_valid_reg;
    logic [ITEM_W-1:0] out_data_reg;
    logic              out_last_reg;

    // Input side
    logic                    accept;
    logic [LEVEL_W-1:0]      lvl_in;
    logic [3:0]              shamt;
    logic signed [CAM_W-1:0] cam_x, cam_y;
    logic signed [VAL_W-1:0] sx_in, sy_in;

    assign cam_x  = s_tdata[CAM_W-1:0];
    assign cam_y  = s_tdata[2*CAM_W-1:CAM_W];
    assign lvl_in = (zoom_reg > MAX_LEVEL) ? MAX_LEVEL : zoom_reg;
    assign shamt  = BASE_SHIFT - {1'b0, lvl_in};
    assign sx_in  = VAL_W'(cam_x >>> shamt);
    assign sy_in  = VAL_W'(cam_y >>> shamt);

    // Shared divider datapath
    logic signed [VAL_W-1:0] opnd;
    logic                    is_div5;
    logic [U_W-1:0]          div_sel, ofs_sel, u_in, q0, dq, r0, q_fix, r_fix;
    logic [RECIP_SHIFT-1:0]  recip_sel;
    logic                    fix;
    logic signed [TILE_W-1:0] q_signed;

    always_comb begin
        case (dop_reg)
            DOP_DIVX: opnd = sx_reg;
            DOP_DIVY: opnd = sy_reg;
            DOP_MODX: opnd = VAL_W'(cx_reg) - VAL_W'(HALF);
            default:  opnd = VAL_W'(cy_reg) - VAL_W'(HALF);
        endcase
    end

    assign is_div5   = (dop_reg == DOP_DIVX) || (dop_reg == DOP_DIVY);
    assign div_sel   = is_div5 ? U_W'(TILE_DIV) : U_W'(GRID_SIZE);
    assign ofs_sel   = is_div5 ? OFS5 : OFSG;
    assign recip_sel = is_div5 ? RECIP5 : RECIPG;
    assign u_in      = U_W'(opnd) + ofs_sel;

    // Reciprocal estimate is exact or one low; one compare corrects it
    assign q0       = U_W'(prod_reg >> RECIP_SHIFT);
    assign dq       = U_W'(q0 * div_sel);
    assign r0       = u_reg - dq;
    assign fix      = (r0 >= div_sel);
    assign q_fix    = fix ? q0 + U_W'(1) : q0;
    assign r_fix    = fix ? r0 - div_sel : r0;
    assign q_signed = TILE_W'(q_fix - BIAS);

    // Per-slot evaluation
    logic signed [D_W-1:0] rel_x, rel_y, nx, ny;
    logic                  miss_x, miss_y, hit, last_slot;
    logic [ITEM_W-1:0]     new_item;

    assign rel_x = dx_reg + D_W'(i_reg)
                 + ((i_reg < cwr_x_reg) ? D_W'(GRID_SIZE) : D_W'(0));
    assign rel_y = dy_reg + D_W'(j_reg)
                 + ((j_reg < cwr_y_reg) ? D_W'(GRID_SIZE) : D_W'(0));
    assign nx    = bx_reg + D_W'(i_reg)
                 + ((i_reg < nwr_x_reg) ? D_W'(GRID_SIZE) : D_W'(0));
    assign ny    = by_reg + D_W'(j_reg)
                 + ((j_reg < nwr_y_reg) ? D_W'(GRID_SIZE) : D_W'(0));

    // Negative values are caught by the sign bit, the rest by the signed compare
    assign miss_x    = rel_x[D_W-1] || (rel_x >= D_W'(GRID_SIZE));
    assign miss_y    = rel_y[D_W-1] || (rel_y >= D_W'(GRID_SIZE));
    assign hit       = miss_x || miss_y;
    assign last_slot = (i_reg == IDX_LAST) && (j_reg == IDX_LAST);
    assign new_item  = {level_reg, TILE_W'(ny), TILE_W'(nx), SLOT_W'(slot_reg)};

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_MUL;
            end
            S_MUL: state_next = S_FIX;
            S_FIX: begin
                if (dop_reg == DOP_DIVY)      state_next = S_CMP;
                else if (dop_reg == DOP_MODY) state_next = S_PREP;
                else                          state_next = S_MUL;
            end
            S_CMP: begin
                if (cx_reg == cen_x_reg && cy_reg == cen_y_reg) state_next = S_IDLE;
                else                                             state_next = S_MUL;
            end
            S_PREP: state_next = S_WALK;
            S_WALK: begin
                if ((!out_valid_reg || m_tready) && last_slot) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!out_valid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    logic out_free, walk_go, drain_go, load_out;

    always_comb begin
        s_tready = (state_reg == S_IDLE);
        out_free = !out_valid_reg || m_tready;
        walk_go  = (state_reg == S_WALK) && out_free;
        drain_go = (state_reg == S_DRAIN) && out_free;
        load_out = (walk_go && hit && pend_valid_reg) || (drain_go && pend_valid_reg);
    end

    assign accept = s_tvalid && s_tready;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            dop_reg        <= DOP_DIVX;
            zoom_reg       <= ZOOM_RESET;
            cen_x_reg      <= TILE_W'(RESET_CENTRE);
            cen_y_reg      <= TILE_W'(RESET_CENTRE);
            cwr_x_reg      <= RESET_WRAP;
            cwr_y_reg      <= RESET_WRAP;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) zoom_reg <= cfg_wr_data;

            if (accept) begin
                dop_reg <= DOP_DIVX;
                if (s_tuser == OP_FORCE) begin
                    cen_x_reg <= TILE_W'(FORCE_CENTRE);
                    cen_y_reg <= TILE_W'(FORCE_CENTRE);
                    cwr_x_reg <= FORCE_WRAP;
                    cwr_y_reg <= FORCE_WRAP;
                end
            end else if (state_reg == S_FIX) begin
                if (dop_reg == DOP_DIVX)      dop_reg <= DOP_DIVY;
                else if (dop_reg == DOP_MODX) dop_reg <= DOP_MODY;
            end else if (state_reg == S_CMP) begin
                dop_reg <= DOP_MODX;
            end

            if (walk_go && hit) begin
                pend_valid_reg <= 1'b1;
            end else if (drain_go) begin
                pend_valid_reg <= 1'b0;
            end

            // Stored centre moves once the run is out
            if (drain_go) begin
                cen_x_reg <= cx_reg;
                cen_y_reg <= cy_reg;
                cwr_x_reg <= nwr_x_reg;
                cwr_y_reg <= nwr_y_reg;
            end

            if (load_out)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            level_reg <= lvl_in;
            sx_reg    <= sx_in;
            sy_reg    <= sy_in;
        end

        if (state_reg == S_MUL) begin
            prod_reg <= PROD_W'(u_in) * PROD_W'(recip_sel);
            u_reg    <= u_in;
        end

        if (state_reg == S_FIX) begin
            case (dop_reg)
                DOP_DIVX: cx_reg    <= q_signed;
                DOP_DIVY: cy_reg    <= q_signed;
                DOP_MODX: nwr_x_reg <= IDX_W'(r_fix);
                default:  nwr_y_reg <= IDX_W'(r_fix);
            endcase
        end

        if (state_reg == S_PREP) begin
            // old window start minus its wrap, relative to the new start
            dx_reg   <= D_W'(cen_x_reg) - D_W'(cwr_x_reg) - D_W'(cx_reg);
            dy_reg   <= D_W'(cen_y_reg) - D_W'(cwr_y_reg) - D_W'(cy_reg);
            bx_reg   <= D_W'(cx_reg) - D_W'(HALF) - D_W'(nwr_x_reg);
            by_reg   <= D_W'(cy_reg) - D_W'(HALF) - D_W'(nwr_y_reg);
            i_reg    <= '0;
            j_reg    <= '0;
            slot_reg <= '0;
        end

        if (walk_go) begin
            if (i_reg == IDX_LAST) begin
                i_reg <= '0;
                j_reg <= j_reg + IDX_W'(1);
            end else begin
                i_reg <= i_reg + IDX_W'(1);
            end
            slot_reg <= slot_reg + SLOT_CNT_W'(1);
            if (hit) pend_data_reg <= new_item;
        end

        // One-deep hold-back so the final slot can carry tlast
        if (load_out) begin
            out_data_reg <= pend_data_reg;
            out_last_reg <= drain_go;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(56 - ITEM_W)'(0), out_data_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted twice in a row");

    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == S_WALK || state_reg == S_DRAIN))
        else $error("held slot outside of a walk");

    a_div_correct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIX) |-> (r0 < (div_sel << 1)))
        else $error("reciprocal estimate off by more than one");

    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (i_reg <= IDX_LAST && j_reg <= IDX_LAST))
        else $error("slot counter out of range");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for toroidal_tile_window_update_top.
// Drives camera positions on the s_ stream, predicts the reassigned ring slots
// in SV and checks every m_ transfer in order. Depends only on ttwu_pkg and the RTL.
module testbench
    import ttwu_pkg::*;
();

    localparam int RING        = DEF_GRID_SIZE;
    localparam int CAM_MAX     = 8388607;
    localparam int CAM_MIN     = -8388608;
    localparam int SETTLE      = 16;    // covers the busy time of an item that moves nothing
    localparam int END_CYCLES  = 80;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 26;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [TILE_W-1:0]  tx;
        logic [TILE_W-1:0]  ty;
        logic [LEVEL_W-1:0] lvl;
        logic               last;
    } slot_result_t;

    // one directed camera input; want_n < 0 means the predictor alone decides
    typedef struct {
        logic [LEVEL_W-1:0] zoom;
        logic               op;
        int                 cam_x;
        int                 cam_y;
        int                 want_n;
    } cam_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [LEVEL_W-1:0] cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;    // cam_x[23:0], cam_y[47:24]
    logic               s_tuser;    // op
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;    // slot_index[5:0], tile_x[26:6], tile_y[47:27],
                                    // tile_level[50:48]
    logic               m_tlast;    // last_of_run

    // predictor state
    logic [LEVEL_W-1:0] zoom_reg;
    int                 ring_cx;
    int                 ring_cy;
    slot_result_t       pending_slots[$];

    // directed stimulus table
    cam_row_t plan[$];

    int errors;
    int n_items;
    int n_forced;
    int n_slots;
    int n_zoom_writes;
    int burst_left;
    int idle_cycles;
    int rx_mode;
    int rx_count;

    toroidal_tile_window_update_top #(
        .GRID_SIZE(RING)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic void add_row(input logic [LEVEL_W-1:0] zoom, input logic op,
                                    input int cam_x, input int cam_y, input int want_n);
        cam_row_t row;
        row.zoom   = zoom;
        row.op     = op;
        row.cam_x  = cam_x;
        row.cam_y  = cam_y;
        row.want_n = want_n;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void queue_slot(input slot_result_t s);
        pending_slots.insert(pending_slots.size(), s);
    endfunction

    function automatic int tile_floor(input int a, input int w);
        int q;
        q = a / w;
        if ((a % w) != 0 && a < 0) begin
            q--;
        end
        return q;
    endfunction

    function automatic int ring_mod(input int a);
        int r;
        r = a % RING;
        if (r < 0) begin
            r += RING;
        end
        return r;
    endfunction

    function automatic int clamp_cam(input int v);
        if (v > CAM_MAX) begin
            return CAM_MAX;
        end
        if (v < CAM_MIN) begin
            return CAM_MIN;
        end
        return v;
    endfunction

    // Tile width in world units at the current effective level
    function automatic int tile_width();
        logic [LEVEL_W-1:0] lvl;
        lvl = (zoom_reg > MAX_LEVEL) ? MAX_LEVEL : zoom_reg;
        return TILE_DIV << (int'(BASE_SHIFT) - int'(lvl));
    endfunction

    // Queues the slots that leave the window for one accepted camera input
    task automatic predict_window(input logic op, input int cam_x, input int cam_y,
                                  output int n_out);
        logic [LEVEL_W-1:0] lvl;
        int w, cx, cy, x0, y0, ox0, oy0, wx0, wy0, owx0, owy0;
        int old_x, old_y, nx, ny, i, j;
        slot_result_t r, held;
        bit have;
        lvl = (zoom_reg > MAX_LEVEL) ? MAX_LEVEL : zoom_reg;
        w = tile_width();
        n_out = 0;
        have = 1'b0;
        held = '0;
        if (op == OP_FORCE) begin
            ring_cx = FORCE_CENTRE;
            ring_cy = FORCE_CENTRE;
        end
        cx = tile_floor(cam_x, w);
        cy = tile_floor(cam_y, w);
        if (cx == ring_cx && cy == ring_cy) begin
            return;
        end
        x0   = cx - RING / 2;
        y0   = cy - RING / 2;
        ox0  = ring_cx - RING / 2;
        oy0  = ring_cy - RING / 2;
        wx0  = ring_mod(x0);
        wy0  = ring_mod(y0);
        owx0 = ring_mod(ox0);
        owy0 = ring_mod(oy0);
        for (j = 0; j < RING; j++) begin
            for (i = 0; i < RING; i++) begin
                old_x = ox0 + i - owx0 + ((i >= owx0) ? 0 : RING);
                old_y = oy0 + j - owy0 + ((j >= owy0) ? 0 : RING);
                if (old_x < x0 || old_x >= x0 + RING || old_y < y0 || old_y >= y0 + RING) begin
                    nx = x0 + i - wx0 + ((i >= wx0) ? 0 : RING);
                    ny = y0 + j - wy0 + ((j >= wy0) ? 0 : RING);
                    r.slot = SLOT_W'(i + j * RING);
                    r.tx   = TILE_W'(nx);
                    r.ty   = TILE_W'(ny);
                    r.lvl  = lvl;
                    r.last = 1'b0;
                    // hold one back so the final slot can carry the last flag
                    if (have) begin
                        queue_slot(held);
                    end
                    held = r;
                    have = 1'b1;
                    n_out++;
                end
            end
        end
        if (have) begin
            held.last = 1'b1;
            queue_slot(held);
        end
        ring_cx = cx;
        ring_cy = cy;
    endtask

    // Sender: bursts with random gaps; returns the number of predicted slots
    task automatic send_camera(input logic op, input int cam_x, input int cam_y,
                               output int n_out);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {CAM_W'(cam_y), CAM_W'(cam_x)};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_items++;
        if (op == OP_FORCE) begin
            n_forced++;
        end
        predict_window(op, cam_x, cam_y, n_out);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_slots.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_zoom(input logic [LEVEL_W-1:0] z);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= z;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        zoom_reg = z;
        n_zoom_writes++;
    endtask

    // Receiver: compare each transfer, stall on a changing pattern
    always @(posedge aclk) begin
        slot_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            n_slots++;
            got.slot = m_tdata[5:0];
            got.tx   = m_tdata[26:6];
            got.ty   = m_tdata[47:27];
            got.lvl  = m_tdata[50:48];
            got.last = m_tlast;
            if (pending_slots.size() == 0) begin
                flag_error($sformatf("unexpected slot=%0d x=%0d y=%0d lvl=%0d last=%0d",
                    got.slot, $signed(got.tx), $signed(got.ty), got.lvl, got.last));
            end else begin
                want = pending_slots.pop_front();
                if (got != want || m_tdata[55:51] != '0) begin
                    flag_error({
                        $sformatf("exp slot=%0d x=%0d y=%0d lvl=%0d last=%0d, ",
                            want.slot, $signed(want.tx), $signed(want.ty), want.lvl,
                            want.last),
                        $sformatf("got slot=%0d x=%0d y=%0d lvl=%0d last=%0d pad=%h",
                            got.slot, $signed(got.tx), $signed(got.ty), got.lvl,
                            got.last, m_tdata[55:51])});
                end
            end
        end
        rx_count++;
        if (rx_count % 64 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= ($urandom_range(0, 9) < 3);
            default: m_tready <= ((rx_count % 16) < 12);
        endcase
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [LEVEL_W-1:0] zoom_order[PHASES];
        logic [CAM_W-1:0] raw;
        logic op;
        int n, k, ph, w, mode, x, y;

        errors        = 0;
        n_items       = 0;
        n_forced      = 0;
        n_slots       = 0;
        n_zoom_writes = 0;
        burst_left    = 0;
        rx_mode       = 0;
        rx_count      = 0;
        zoom_reg      = ZOOM_RESET;
        ring_cx       = RESET_CENTRE;
        ring_cy       = RESET_CENTRE;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_UPDATE;

        // zoom 4: tile width 320
        add_row(3'd4, OP_UPDATE, 0, 0, RING * RING);            // from reset centre
        add_row(3'd4, OP_UPDATE, 319, 100, 0);                  // same tile
        add_row(3'd4, OP_UPDATE, 320, 0, RING);                 // one column
        add_row(3'd4, OP_UPDATE, 320, -1, RING);                // one row
        add_row(3'd4, OP_UPDATE, -1, -1, 2 * RING);             // two columns
        add_row(3'd4, OP_FORCE, -1, -1, RING * RING);
        add_row(3'd4, OP_UPDATE, CAM_MAX, CAM_MAX, RING * RING);
        add_row(3'd4, OP_UPDATE, CAM_MIN, CAM_MIN, RING * RING);
        add_row(3'd4, OP_UPDATE, CAM_MIN, CAM_MAX, RING * RING);
        add_row(3'd4, OP_UPDATE, CAM_MIN + 960, CAM_MAX - 640, -1);
        // zoom 0: widest tiles
        add_row(3'd0, OP_UPDATE, 5119, 0, RING * RING);
        add_row(3'd0, OP_UPDATE, 5120, -1, -1);
        add_row(3'd0, OP_UPDATE, -5120, -5121, -1);
        add_row(3'd0, OP_UPDATE, CAM_MAX, CAM_MIN, RING * RING);
        // zoom 6: a forced update that lands on the forced centre moves nothing
        add_row(3'd6, OP_UPDATE, -800000, -800000, RING * RING);
        add_row(3'd6, OP_FORCE, -800000, -799921, 0);
        add_row(3'd6, OP_FORCE, -800001, -800000, RING);
        // zoom 7 saturates to level 6
        add_row(3'd7, OP_UPDATE, 79, 80, RING * RING);
        add_row(3'd7, OP_FORCE, -80, -81, RING * RING);
        add_row(3'd7, OP_UPDATE, -1, 160, -1);
        add_row(3'd5, OP_UPDATE, 0, 0, -1);
        add_row(3'd5, OP_FORCE, 1, 1, RING * RING);

        zoom_order = '{3'd5, 3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd3, 3'd4};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            if (plan[r].zoom != zoom_reg) begin
                apply_zoom(plan[r].zoom);
            end
            send_camera(plan[r].op, plan[r].cam_x, plan[r].cam_y, n);
            if (plan[r].want_n >= 0 && n != plan[r].want_n) begin
                flag_error($sformatf("row %0d: expected %0d slots, predicted %0d",
                    r, plan[r].want_n, n));
            end
        end

        // Random part: mostly nearby camera moves so the walk sees partial
        // reassignments, mixed with jumps, forced updates and noise.
        x = 0;
        y = 0;
        for (ph = 0; ph < PHASES; ph++) begin
            apply_zoom(zoom_order[ph]);
            w = tile_width();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                mode = $urandom_range(0, 99);
                op = ($urandom_range(0, 19) == 0) ? OP_FORCE : OP_UPDATE;
                if (mode < 12) begin
                    x = clamp_cam(x + $urandom_range(0, w) - w / 2);
                    y = clamp_cam(y + $urandom_range(0, w) - w / 2);
                end else if (mode < 65) begin
                    x = clamp_cam(x + ($urandom_range(0, 6) - 3) * w + $urandom_range(0, w - 1));
                    y = clamp_cam(y + ($urandom_range(0, 6) - 3) * w + $urandom_range(0, w - 1));
                end else if (mode < 75) begin
                    x = clamp_cam(x + ($urandom_range(0, 20) - 10) * w);
                    y = clamp_cam(y + ($urandom_range(0, 20) - 10) * w);
                end else if (mode < 83) begin
                    raw = CAM_W'($urandom);
                    x = int'($signed(raw));
                    raw = CAM_W'($urandom);
                    y = int'($signed(raw));
                end else if (mode < 92) begin
                    op = OP_FORCE;
                    x = clamp_cam(x + ($urandom_range(0, 2) - 1) * w);
                end else begin
                    x = $urandom_range(0, 1) ? CAM_MAX : CAM_MIN;
                    y = $urandom_range(0, 1) ? CAM_MAX : CAM_MIN;
                end
                send_camera(op, x, y, n);
                if ($urandom_range(0, 24) == 0) begin
                    wait_drained();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);

        $display("Sent %0d camera inputs (%0d forced) across %0d zoom writes, levels 0 to 7",
            n_items, n_forced, n_zoom_writes);
        $display("Checked %0d slot transfers, %0d mismatches", n_slots, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
